>>> rtl/core/seat_pressure_posture_classifier_macros.svh
// ----------------------------------------------------------------------------
// Seat pressure posture classifier assertion macros
// Concurrent assertion shorthands clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SEAT_PRESSURE_POSTURE_CLASSIFIER_MACROS_SVH
`define SEAT_PRESSURE_POSTURE_CLASSIFIER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPPC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/sppc_pkg.sv
// ----------------------------------------------------------------------------
// sppc_pkg
// Shared types and constants of the seat pressure posture classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package sppc_pkg;

	localparam int CELL_W    = 8;
	localparam int NUM_CELLS = 8;
	localparam int PADDR_W   = 5;

	localparam logic [2:0] REG_CHAIR_ADDRESS     = 3'd0;
	localparam logic [2:0] REG_SEAT_THRESHOLD    = 3'd1;
	localparam logic [2:0] REG_POSTURE_THRESHOLD = 3'd2;
	localparam logic [2:0] REG_LEAN_MARGIN       = 3'd3;
	localparam logic [2:0] REG_EMPTY_BACK_THRESH = 3'd4;
	localparam logic [2:0] REG_MAX_SIT_SECONDS   = 3'd5;
	localparam logic [2:0] REG_SECONDS_PER_FRAME = 3'd6;

	localparam logic [2:0] CLASS_GOOD       = 3'd0;
	localparam logic [2:0] CLASS_HUNCH      = 3'd1;
	localparam logic [2:0] CLASS_LEAN_LEFT  = 3'd2;
	localparam logic [2:0] CLASS_LEAN_RIGHT = 3'd3;
	localparam logic [2:0] CLASS_SLOUCH     = 3'd4;

	localparam logic [6:0] SCORE_RESET  = 7'd100;
	localparam logic [6:0] SCORE_STAND  = 7'd95;
	localparam logic [6:0] SCORE_GOOD   = 7'd85;
	localparam logic [6:0] SCORE_LEAN   = 7'd55;
	localparam logic [6:0] SCORE_SLOUCH = 7'd40;
	localparam logic [6:0] SCORE_HUNCH  = 7'd30;

	localparam logic [6:0] RISK_HIGH_LIMIT = 7'd60;
	localparam logic [6:0] RISK_MID_LIMIT  = 7'd30;
	localparam logic [1:0] LEVEL_LOW       = 2'd0;
	localparam logic [1:0] LEVEL_MID       = 2'd1;
	localparam logic [1:0] LEVEL_HIGH      = 2'd2;

	localparam logic [9:0] RISK_FULL   = 10'd100;
	localparam logic [3:0] RISK_KEEP   = 4'd9;
	localparam logic [7:0] DIV10_MUL   = 8'd205;
	localparam int         DIV10_SHIFT = 11;

	localparam logic [15:0] RST_CHAIR_ADDRESS     = 16'd0;
	localparam logic [10:0] RST_SEAT_THRESHOLD    = 11'd200;
	localparam logic [7:0]  RST_POSTURE_THRESHOLD = 8'd40;
	localparam logic [7:0]  RST_LEAN_MARGIN       = 8'd30;
	localparam logic [7:0]  RST_EMPTY_BACK_THRESH = 8'd10;
	localparam logic [15:0] RST_MAX_SIT_SECONDS   = 16'd3600;
	localparam logic [7:0]  RST_SECONDS_PER_FRAME = 8'd1;

	typedef struct packed {
		logic [15:0] chair_address;
		logic [10:0] seat_threshold;
		logic [7:0]  posture_threshold;
		logic [7:0]  lean_margin;
		logic [7:0]  empty_back_threshold;
		logic [15:0] max_sit_seconds;
		logic [7:0]  seconds_per_frame;
	} cfg_t;

	typedef struct packed {
		logic       accepted;
		logic       sitting;
		logic [2:0] pose_class;
		logic [6:0] pose_score;
		logic       break_ack;
	} frame_rec_t;

	typedef struct packed {
		logic        accepted;
		logic [2:0]  pose_class;
		logic [6:0]  pose_score;
		logic [6:0]  risk_average;
		logic [1:0]  strain_level;
		logic [15:0] sit_seconds;
		logic [15:0] stand_seconds;
		logic        break_request;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/core/sppc_regs.sv
// ----------------------------------------------------------------------------
// sppc_regs
// Configuration register file behind an APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module sppc_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [sppc_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready,
	output sppc_pkg::cfg_t                    cfg
);

	sppc_pkg::cfg_t cfg_q;
	logic [2:0]     reg_idx;
	logic           wr_en;

	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chair_address        <= sppc_pkg::RST_CHAIR_ADDRESS;
			cfg_q.seat_threshold       <= sppc_pkg::RST_SEAT_THRESHOLD;
			cfg_q.posture_threshold    <= sppc_pkg::RST_POSTURE_THRESHOLD;
			cfg_q.lean_margin          <= sppc_pkg::RST_LEAN_MARGIN;
			cfg_q.empty_back_threshold <= sppc_pkg::RST_EMPTY_BACK_THRESH;
			cfg_q.max_sit_seconds      <= sppc_pkg::RST_MAX_SIT_SECONDS;
			cfg_q.seconds_per_frame    <= sppc_pkg::RST_SECONDS_PER_FRAME;
		end else if (wr_en) begin
			unique case (reg_idx)
				sppc_pkg::REG_CHAIR_ADDRESS:     cfg_q.chair_address        <= pwdata[15:0];
				sppc_pkg::REG_SEAT_THRESHOLD:    cfg_q.seat_threshold       <= pwdata[10:0];
				sppc_pkg::REG_POSTURE_THRESHOLD: cfg_q.posture_threshold    <= pwdata[7:0];
				sppc_pkg::REG_LEAN_MARGIN:       cfg_q.lean_margin          <= pwdata[7:0];
				sppc_pkg::REG_EMPTY_BACK_THRESH: cfg_q.empty_back_threshold <= pwdata[7:0];
				sppc_pkg::REG_MAX_SIT_SECONDS:   cfg_q.max_sit_seconds      <= pwdata[15:0];
				sppc_pkg::REG_SECONDS_PER_FRAME: cfg_q.seconds_per_frame    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			sppc_pkg::REG_CHAIR_ADDRESS:     prdata = 32'(cfg_q.chair_address);
			sppc_pkg::REG_SEAT_THRESHOLD:    prdata = 32'(cfg_q.seat_threshold);
			sppc_pkg::REG_POSTURE_THRESHOLD: prdata = 32'(cfg_q.posture_threshold);
			sppc_pkg::REG_LEAN_MARGIN:       prdata = 32'(cfg_q.lean_margin);
			sppc_pkg::REG_EMPTY_BACK_THRESH: prdata = 32'(cfg_q.empty_back_threshold);
			sppc_pkg::REG_MAX_SIT_SECONDS:   prdata = 32'(cfg_q.max_sit_seconds);
			sppc_pkg::REG_SECONDS_PER_FRAME: prdata = 32'(cfg_q.seconds_per_frame);
			default:                         prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/core/sppc_front.sv
// ----------------------------------------------------------------------------
// sppc_front
// Frame filter and posture classifier; builds one record per frame.
// ----------------------------------------------------------------------------
`default_nettype none

module sppc_front (
	input  wire sppc_pkg::cfg_t   cfg,
	input  wire logic [15:0]      source_address,
	input  wire logic             frame_valid,
	input  wire logic [63:0]      back_cells,
	input  wire logic [63:0]      seat_cells,
	input  wire logic             break_ack,
	output sppc_pkg::frame_rec_t  rec
);

	logic [10:0] seat_sum;
	logic [8:0]  left_sum;
	logic [8:0]  right_sum;
	logic [9:0]  upper_sum;
	logic [9:0]  lower_sum;
	logic [7:0]  left_avg;
	logic [7:0]  right_avg;
	logic [7:0]  upper_avg;
	logic [7:0]  lower_avg;
	logic        is_hunch;
	logic        is_lean_left;
	logic        is_lean_right;
	logic        is_slouch;

	always_comb begin
		seat_sum = '0;
		for (int i = 0; i < sppc_pkg::NUM_CELLS; i++) begin
			seat_sum = seat_sum + 11'(seat_cells[sppc_pkg::CELL_W*i +: sppc_pkg::CELL_W]);
		end
	end

	assign left_sum  = 9'(seat_cells[7:0])   + 9'(seat_cells[23:16]);
	assign right_sum = 9'(seat_cells[31:24]) + 9'(seat_cells[47:40]);
	assign upper_sum = 10'(back_cells[7:0])   + 10'(back_cells[15:8])
	                 + 10'(back_cells[23:16]) + 10'(back_cells[31:24]);
	assign lower_sum = 10'(back_cells[39:32]) + 10'(back_cells[47:40])
	                 + 10'(back_cells[55:48]) + 10'(back_cells[63:56]);

	assign left_avg  = left_sum[8:1];
	assign right_avg = right_sum[8:1];
	assign upper_avg = upper_sum[9:2];
	assign lower_avg = lower_sum[9:2];

	assign is_hunch      = (upper_avg > cfg.posture_threshold)
	                    && (lower_avg < cfg.empty_back_threshold);
	assign is_lean_left  = 9'(left_avg) > (9'(right_avg) + 9'(cfg.lean_margin));
	assign is_lean_right = 9'(right_avg) > (9'(left_avg) + 9'(cfg.lean_margin));
	assign is_slouch     = (lower_avg > cfg.posture_threshold)
	                    && (upper_avg < cfg.empty_back_threshold);

	always_comb begin
		rec.accepted  = frame_valid && (source_address == cfg.chair_address);
		rec.sitting   = seat_sum > cfg.seat_threshold;
		rec.break_ack = break_ack;
		if (!rec.sitting) begin
			rec.pose_class = sppc_pkg::CLASS_GOOD;
			rec.pose_score = sppc_pkg::SCORE_STAND;
		end else if (is_hunch) begin
			rec.pose_class = sppc_pkg::CLASS_HUNCH;
			rec.pose_score = sppc_pkg::SCORE_HUNCH;
		end else if (is_lean_left) begin
			rec.pose_class = sppc_pkg::CLASS_LEAN_LEFT;
			rec.pose_score = sppc_pkg::SCORE_LEAN;
		end else if (is_lean_right) begin
			rec.pose_class = sppc_pkg::CLASS_LEAN_RIGHT;
			rec.pose_score = sppc_pkg::SCORE_LEAN;
		end else if (is_slouch) begin
			rec.pose_class = sppc_pkg::CLASS_SLOUCH;
			rec.pose_score = sppc_pkg::SCORE_SLOUCH;
		end else begin
			rec.pose_class = sppc_pkg::CLASS_GOOD;
			rec.pose_score = sppc_pkg::SCORE_GOOD;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/sppc_queue.sv
// ----------------------------------------------------------------------------
// sppc_queue
// Small FIFO of classified frame records between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module sppc_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push_valid,
	output logic                      push_ready,
	input  wire sppc_pkg::frame_rec_t push_data,
	output logic                      pop_valid,
	input  wire logic                 pop_ready,
	output sppc_pkg::frame_rec_t      pop_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	sppc_pkg::frame_rec_t entry_q [DEPTH];
	logic [AW-1:0]        wr_ptr_q;
	logic [AW-1:0]        rd_ptr_q;
	logic [CW-1:0]        count_q;
	logic                 push;
	logic                 pop;

	assign push_ready = count_q != CW'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/sppc_back.sv
// ----------------------------------------------------------------------------
// sppc_back
// Session state: sit and stand timers, risk average, break request, and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sppc_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire sppc_pkg::cfg_t       cfg,
	input  wire logic                 rec_valid,
	output logic                      rec_ready,
	input  wire sppc_pkg::frame_rec_t rec,
	output logic                      res_valid,
	input  wire logic                 res_ready,
	output sppc_pkg::result_t         res
);

	logic [2:0]        class_q;
	logic [6:0]        score_q;
	logic [6:0]        risk_q;
	logic [15:0]       sit_q;
	logic [15:0]       stand_q;
	logic              pend_q;
	logic              res_valid_q;
	sppc_pkg::result_t res_q;

	logic              advance;
	logic              pend_acked;
	logic [16:0]       sit_sum;
	logic [16:0]       stand_sum;
	logic [15:0]       sit_sat;
	logic [15:0]       stand_sat;
	logic              raise;
	logic [9:0]        risk_mix;
	logic [17:0]       risk_prod;
	logic [6:0]        risk_next;

	logic [2:0]        class_n;
	logic [6:0]        score_n;
	logic [6:0]        risk_n;
	logic [15:0]       sit_n;
	logic [15:0]       stand_n;
	logic              pend_n;
	logic              req_n;

	assign rec_ready = !res_valid_q || res_ready;
	assign advance   = rec_valid && rec_ready;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign pend_acked = pend_q && !rec.break_ack;
	assign sit_sum    = 17'(sit_q) + 17'(cfg.seconds_per_frame);
	assign stand_sum  = 17'(stand_q) + 17'(cfg.seconds_per_frame);
	assign sit_sat    = sit_sum[16] ? 16'hFFFF : sit_sum[15:0];
	assign stand_sat  = stand_sum[16] ? 16'hFFFF : stand_sum[15:0];
	assign raise      = (sit_sat >= cfg.max_sit_seconds) && !pend_acked;

	// Division by ten as a multiply by 205/2048, exact below 1029.
	assign risk_mix  = 10'(risk_q) * 10'(sppc_pkg::RISK_KEEP)
	                 + sppc_pkg::RISK_FULL - 10'(rec.pose_score);
	assign risk_prod = 18'(risk_mix) * 18'(sppc_pkg::DIV10_MUL);
	assign risk_next = risk_prod[sppc_pkg::DIV10_SHIFT +: 7];

	always_comb begin
		class_n = class_q;
		score_n = score_q;
		risk_n  = risk_q;
		sit_n   = sit_q;
		stand_n = stand_q;
		pend_n  = pend_acked;
		req_n   = 1'b0;
		if (rec.accepted) begin
			class_n = rec.pose_class;
			score_n = rec.pose_score;
			risk_n  = risk_next;
			if (rec.sitting) begin
				sit_n   = sit_sat;
				stand_n = '0;
				req_n   = raise;
				pend_n  = pend_acked || raise;
			end else begin
				sit_n   = '0;
				stand_n = stand_sat;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_q     <= sppc_pkg::CLASS_GOOD;
			score_q     <= sppc_pkg::SCORE_RESET;
			risk_q      <= '0;
			sit_q       <= '0;
			stand_q     <= '0;
			pend_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				class_q     <= class_n;
				score_q     <= score_n;
				risk_q      <= risk_n;
				sit_q       <= sit_n;
				stand_q     <= stand_n;
				pend_q      <= pend_n;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.accepted      <= rec.accepted;
			res_q.pose_class    <= class_n;
			res_q.pose_score    <= score_n;
			res_q.risk_average  <= risk_n;
			res_q.sit_seconds   <= sit_n;
			res_q.stand_seconds <= stand_n;
			res_q.break_request <= req_n;
			if (risk_n > sppc_pkg::RISK_HIGH_LIMIT) begin
				res_q.strain_level <= sppc_pkg::LEVEL_HIGH;
			end else if (risk_n > sppc_pkg::RISK_MID_LIMIT) begin
				res_q.strain_level <= sppc_pkg::LEVEL_MID;
			end else begin
				res_q.strain_level <= sppc_pkg::LEVEL_LOW;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/seat_pressure_posture_classifier.sv
// ----------------------------------------------------------------------------
// seat_pressure_posture_classifier
// Chair pressure frame filter, posture classifier and sitting session tracker.
// ----------------------------------------------------------------------------
// The block takes one pressure frame per clock cycle while item_ready is high
// and returns exactly one result per frame, in order. A frame transfer is
// classified in the same cycle and stored in a short record queue; the session
// stage then updates the timers, the risk average and the break flag for one
// record per cycle while results are taken and places the result in an output
// register. The sustained rate of one frame per cycle is set by the session
// stage, where each frame's risk average builds on the one before it. While
// results are held back the queue absorbs up to QUEUE_DEPTH frames before
// item_ready drops. Configuration writes take effect at once and should be made
// only while no frame is in flight.
`default_nettype none

`include "seat_pressure_posture_classifier_macros.svh"

module seat_pressure_posture_classifier #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [sppc_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready,
	input  wire logic                         item_valid,
	output logic                              item_ready,
	input  wire logic [15:0]                  source_address,
	input  wire logic                         frame_valid,
	input  wire logic [63:0]                  back_cells,
	input  wire logic [63:0]                  seat_cells,
	input  wire logic                         break_ack,
	output logic                              result_valid,
	input  wire logic                         result_ready,
	output logic                              accepted,
	output logic      [2:0]                   pose_class,
	output logic      [6:0]                   pose_score,
	output logic      [6:0]                   risk_average,
	output logic      [1:0]                   strain_level,
	output logic      [15:0]                  sit_seconds,
	output logic      [15:0]                  stand_seconds,
	output logic                              break_request
);

	sppc_pkg::cfg_t       cfg;
	sppc_pkg::frame_rec_t front_rec;
	sppc_pkg::frame_rec_t queue_rec;
	logic                 queue_valid;
	logic                 queue_ready;
	sppc_pkg::result_t    res;

	logic                 brk_shown;
	logic                 sit_limit_met;
	logic                 timers_apart;
	logic                 stand_shown;
	logic                 stand_pose;
	logic                 rec_moved;

	sppc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sppc_front u_front (
		.cfg            (cfg),
		.source_address (source_address),
		.frame_valid    (frame_valid),
		.back_cells     (back_cells),
		.seat_cells     (seat_cells),
		.break_ack      (break_ack),
		.rec            (front_rec)
	);

	sppc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (item_valid),
		.push_ready (item_ready),
		.push_data  (front_rec),
		.pop_valid  (queue_valid),
		.pop_ready  (queue_ready),
		.pop_data   (queue_rec)
	);

	sppc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.rec_valid (queue_valid),
		.rec_ready (queue_ready),
		.rec       (queue_rec),
		.res_valid (result_valid),
		.res_ready (result_ready),
		.res       (res)
	);

	assign accepted      = res.accepted;
	assign pose_class    = res.pose_class;
	assign pose_score    = res.pose_score;
	assign risk_average  = res.risk_average;
	assign strain_level  = res.strain_level;
	assign sit_seconds   = res.sit_seconds;
	assign stand_seconds = res.stand_seconds;
	assign break_request = res.break_request;

	assign brk_shown     = result_valid && break_request;
	assign sit_limit_met = sit_seconds >= cfg.max_sit_seconds;
	assign timers_apart  = (sit_seconds == '0) || (stand_seconds == '0);
	assign stand_shown   = result_valid && accepted && (stand_seconds != '0);
	assign stand_pose    = (pose_class == sppc_pkg::CLASS_GOOD)
	                    && (pose_score == sppc_pkg::SCORE_STAND);
	assign rec_moved     = queue_valid && queue_ready;

	`SPPC_ASSERT_SAME(a_break_needs_accept, brk_shown, accepted, "break on a rejected frame")
	`SPPC_ASSERT_SAME(a_break_limit, brk_shown, sit_limit_met, "break below the sitting limit")
	`SPPC_ASSERT_SAME(a_timers_apart, result_valid, timers_apart, "both timers running")
	`SPPC_ASSERT_SAME(a_standing_is_good, stand_shown, stand_pose, "standing frame not good")
	`SPPC_ASSERT_NEXT(a_queue_feeds_back, rec_moved, result_valid, "record without a result")

endmodule

`default_nettype wire
